### rtl/core/adagrad_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// AdaGrad step update package
// Shared transfer types, register indexes and defaults for the step block.
// ----------------------------------------------------------------------------
package adagrad_pkg;

   localparam int unsigned NUM_PARAMS_DEFAULT = 4096;
   localparam logic [31:0] STEP_SIZE_RESET = 32'h0001_0000;
   localparam logic [31:0] EPSILON_RESET = 32'h0000_0001;

   localparam logic CSR_STEP_SIZE = 1'b0;
   localparam logic CSR_EPSILON_BIAS = 1'b1;

   localparam logic MODE_UPDATE = 1'b0;
   localparam logic MODE_CLEAR = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [11:0] param_index;
      logic signed [31:0] gradient;
   } req_type;

   typedef struct packed {
      logic [11:0] result_index;
      logic signed [31:0] step;
      logic        saturated;
   } rsp_type;

   typedef struct packed {
      logic        active;
      logic        neg;
      logic        sat;
      logic        zero;
      logic        ovf;
      logic [11:0] idx;
      logic [62:0] num;
   } pipe_type;

endpackage
`default_nettype wire

### rtl/core/adagrad_step_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// AdaGrad step update
// Accumulates squared gradients per parameter and returns the scaled step.
// ----------------------------------------------------------------------------
// Takes one item per cycle unless rsp_stall, a clear item or a sweep holds it.
// The depth comes from the 32-stage square root and the 32-stage divider.
// Accumulators live in one synchronous memory with a forwarded write-back.
// After reset, and after each clear item, a clearing pass zeroes every
// memory entry; no input transfer is taken during that pass.
module adagrad_step_update #(
   parameter int unsigned NUM_PARAMS = adagrad_pkg::NUM_PARAMS_DEFAULT
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire adagrad_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output adagrad_pkg::rsp_type  rsp_data,
   input  wire                   csr_we,
   input  wire                   csr_index,
   input  wire [31:0]            csr_wdata
);

   localparam int unsigned AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
   localparam int unsigned NSQ = 32;
   localparam int unsigned NDV = 32;

   logic [31:0] step_size_ff;
   logic [31:0] epsilon_ff;

   logic [63:0] mem [NUM_PARAMS];
   logic [63:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic mem_we;
   logic [AW-1:0] mem_waddr;
   logic [63:0] mem_wdata;

   logic sweep_busy_ff;
   logic [AW-1:0] sweep_cnt_ff;

   logic adv;
   logic req_acc;

   logic s1_vld_ff, s1_clr_ff, s1_act_ff, s1_neg_ff;
   logic [11:0] s1_idx_ff;
   logic [63:0] s1_sq_ff;
   logic [62:0] s1_num_ff;
   logic [AW-1:0] s1_addr;

   logic fwd_vld_ff;
   logic [AW-1:0] fwd_idx_ff;
   logic [63:0] fwd_data_ff;

   logic [63:0] acc;
   logic [64:0] sum_wide;
   logic [63:0] sum_new;

   logic [31:0] gmag;
   logic in_range;

   logic sq_v_ff [NSQ+1];
   adagrad_pkg::pipe_type sq_p_ff [NSQ+1];
   logic [63:0] sq_rem_ff [NSQ+1];
   logic [63:0] sq_root_ff [NSQ+1];

   logic dv_v_ff [NDV+1];
   adagrad_pkg::pipe_type dv_p_ff [NDV+1];
   adagrad_pkg::pipe_type dv_p_in;
   logic [32:0] dv_rem_ff [NDV+1];
   logic [32:0] dv_d_ff [NDV+1];
   logic [31:0] dv_q_ff [NDV+1];

   logic rsp_valid_ff;
   adagrad_pkg::rsp_type rsp_data_ff;
   adagrad_pkg::rsp_type rsp_in;

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv || sweep_busy_ff || (s1_vld_ff && s1_clr_ff);
   assign req_acc = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff <= adagrad_pkg::STEP_SIZE_RESET;
         epsilon_ff <= adagrad_pkg::EPSILON_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            adagrad_pkg::CSR_STEP_SIZE: step_size_ff <= csr_wdata;
            adagrad_pkg::CSR_EPSILON_BIAS: epsilon_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign gmag = req_data.gradient[31] ? (~req_data.gradient + 32'd1) : req_data.gradient;
   assign in_range = 32'(req_data.param_index) < 32'(NUM_PARAMS);
   assign s1_addr = AW'(s1_idx_ff);
   assign rd_addr = adv ? AW'(req_data.param_index) : s1_addr;

   assign acc = (fwd_vld_ff && fwd_idx_ff == s1_addr) ? fwd_data_ff : rd_data_ff;
   assign sum_wide = {1'b0, acc} + {1'b0, s1_sq_ff};
   assign sum_new = sum_wide[64] ? {64{1'b1}} : sum_wide[63:0];

   assign mem_we = sweep_busy_ff || (adv && s1_vld_ff && s1_act_ff);
   assign mem_waddr = sweep_busy_ff ? sweep_cnt_ff : s1_addr;
   assign mem_wdata = sweep_busy_ff ? 64'd0 : sum_new;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_busy_ff <= 1'b1;
         sweep_cnt_ff <= '0;
         fwd_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
      end else begin
         if (sweep_busy_ff) begin
            sweep_cnt_ff <= sweep_cnt_ff + AW'(1);
            if (sweep_cnt_ff == AW'(NUM_PARAMS - 1)) begin
               sweep_busy_ff <= 1'b0;
            end
         end
         if (adv) begin
            s1_vld_ff <= req_acc;
            if (s1_vld_ff && s1_clr_ff) begin
               sweep_busy_ff <= 1'b1;
               sweep_cnt_ff <= '0;
               fwd_vld_ff <= 1'b0;
            end else if (s1_vld_ff && s1_act_ff) begin
               fwd_vld_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_clr_ff <= req_data.mode == adagrad_pkg::MODE_CLEAR;
         s1_act_ff <= (req_data.mode == adagrad_pkg::MODE_UPDATE) && in_range;
         s1_neg_ff <= req_data.gradient[31];
         s1_idx_ff <= req_data.param_index;
         s1_sq_ff <= 64'(gmag) * 64'(gmag);
         s1_num_ff <= 63'(64'(step_size_ff) * 64'(gmag));
         if (s1_vld_ff && s1_act_ff) begin
            fwd_idx_ff <= s1_addr;
            fwd_data_ff <= sum_new;
         end
      end
   end

   // Square root stages, one result bit each.
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_v_ff[0] <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_rem_ff[0] <= sum_new;
         sq_root_ff[0] <= 64'd0;
         sq_p_ff[0].active <= s1_act_ff;
         sq_p_ff[0].neg <= s1_neg_ff;
         sq_p_ff[0].sat <= s1_act_ff && sum_wide[64];
         sq_p_ff[0].zero <= 1'b0;
         sq_p_ff[0].ovf <= 1'b0;
         sq_p_ff[0].idx <= s1_idx_ff;
         sq_p_ff[0].num <= s1_num_ff;
      end
   end

   for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
      logic [63:0] trial;
      assign trial = sq_root_ff[j] + BIT;
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[j+1] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[j+1] <= sq_v_ff[j];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_p_ff[j+1] <= sq_p_ff[j];
            if (sq_rem_ff[j] >= trial) begin
               sq_rem_ff[j+1] <= sq_rem_ff[j] - trial;
               sq_root_ff[j+1] <= (sq_root_ff[j] >> 1) + BIT;
            end else begin
               sq_rem_ff[j+1] <= sq_rem_ff[j];
               sq_root_ff[j+1] <= sq_root_ff[j] >> 1;
            end
         end
      end
   end

   // Denominator and overflow check feed the divider.
   logic [32:0] denom;
   assign denom = 33'(epsilon_ff) + 33'(sq_root_ff[NSQ][31:0]);

   always_comb begin
      dv_p_in = sq_p_ff[NSQ];
      dv_p_in.zero = denom == 33'd0;
      dv_p_in.ovf = 33'(sq_p_ff[NSQ].num[62:32]) >= denom;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= sq_v_ff[NSQ];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_p_ff[0] <= dv_p_in;
         dv_rem_ff[0] <= 33'(sq_p_ff[NSQ].num[62:32]);
         dv_d_ff[0] <= denom;
         dv_q_ff[0] <= 32'd0;
      end
   end

   for (genvar k = 0; k < NDV; k++) begin : g_div
      logic [33:0] t;
      assign t = {dv_rem_ff[k], dv_p_ff[k].num[NDV-1-k]};
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[k+1] <= dv_v_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_p_ff[k+1] <= dv_p_ff[k];
            dv_d_ff[k+1] <= dv_d_ff[k];
            if (t >= {1'b0, dv_d_ff[k]}) begin
               dv_rem_ff[k+1] <= 33'(t - {1'b0, dv_d_ff[k]});
               dv_q_ff[k+1] <= {dv_q_ff[k][30:0], 1'b1};
            end else begin
               dv_rem_ff[k+1] <= t[32:0];
               dv_q_ff[k+1] <= {dv_q_ff[k][30:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      adagrad_pkg::pipe_type p;
      logic [31:0] q;
      p = dv_p_ff[NDV];
      q = dv_q_ff[NDV];
      rsp_in.result_index = p.idx;
      rsp_in.step = 32'sd0;
      rsp_in.saturated = p.active && p.sat;
      if (p.active && !p.zero) begin
         if (p.neg) begin
            if (p.ovf || q > 32'h7FFF_FFFF) begin
               rsp_in.step = 32'sh7FFF_FFFF;
               rsp_in.saturated = 1'b1;
            end else begin
               rsp_in.step = q;
            end
         end else begin
            if (p.ovf || q > 32'h8000_0000) begin
               rsp_in.step = 32'sh8000_0000;
               rsp_in.saturated = 1'b1;
            end else begin
               rsp_in.step = 32'd0 - q;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_v_ff[NDV];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_in;
      end
   end

`ifndef SYNTH
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sweep_busy_ff |-> !req_acc)
      else $error("input transfer taken during clearing pass");

   a_no_update_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sweep_busy_ff |-> !s1_vld_ff)
      else $error("accumulator update overlaps clearing pass");

   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && s1_clr_ff) |-> !req_acc)
      else $error("input transfer taken behind a clear item");
`endif

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AdaGrad step update testbench
// Streams gradient and clear items into the step block under random idling
// and stalls, predicts every step from its own accumulator copy, and checks
// each result transfer in order.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int NPARAM = 4096;
   localparam int LATENCY = 67;
   localparam int WATCHDOG_LIMIT = 40000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   adagrad_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   adagrad_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic csr_index = adagrad_pkg::CSR_STEP_SIZE;
   logic [31:0] csr_wdata = '0;

   logic [63:0] grad_sq_sum [NPARAM];
   logic [31:0] alpha_q;
   logic [31:0] eps_q;
   adagrad_pkg::rsp_type pending_steps [$];
   int errors = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_clears = 0;
   int n_sat = 0;
   int idle_pct = 31;
   int idle_cycles = 0;

   adagrad_step_update i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] bitv;
      rem = v;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root[31:0];
   endfunction

   function automatic adagrad_pkg::rsp_type adagrad_step(input adagrad_pkg::req_type r);
      adagrad_pkg::rsp_type o;
      logic neg;
      logic [63:0] gmag;
      logic [63:0] sq;
      logic [64:0] sum;
      logic [63:0] acc;
      logic [63:0] denom;
      logic [63:0] q;
      o = '0;
      o.result_index = r.param_index;
      if (r.mode == adagrad_pkg::MODE_CLEAR) begin
         foreach (grad_sq_sum[i]) grad_sq_sum[i] = '0;
         return o;
      end
      neg = r.gradient[31];
      gmag = neg ? {32'd0, -r.gradient} : {32'd0, r.gradient};
      if (neg && gmag[31:0] == 0) gmag = 64'h8000_0000;
      gmag[63:32] = '0;
      sq = gmag * gmag;
      sum = {1'b0, grad_sq_sum[r.param_index]} + {1'b0, sq};
      if (sum[64]) begin
         acc = '1;
         o.saturated = 1'b1;
      end else begin
         acc = sum[63:0];
      end
      grad_sq_sum[r.param_index] = acc;
      denom = {32'd0, eps_q} + {32'd0, isqrt64(acc)};
      if (denom != 0) begin
         q = ({32'd0, alpha_q} * gmag) / denom;
         if (neg) begin
            if (q > 64'h7FFF_FFFF) begin
               q = 64'h7FFF_FFFF;
               o.saturated = 1'b1;
            end
            o.step = q[31:0];
         end else begin
            if (q > 64'h8000_0000) begin
               q = 64'h8000_0000;
               o.saturated = 1'b1;
            end
            o.step = -q[31:0];
         end
      end
      return o;
   endfunction

   task automatic send_item(input logic mode, input logic [11:0] idx,
                            input logic [31:0] grad);
      adagrad_pkg::req_type r;
      r.mode = mode;
      r.param_index = idx;
      r.gradient = grad;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_steps.push_back(adagrad_step(r));
      if (mode == adagrad_pkg::MODE_CLEAR) n_clears++;
      n_sent++;
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] value);
      req_valid <= 1'b0;
      while (pending_steps.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == adagrad_pkg::CSR_STEP_SIZE) alpha_q = value;
      else eps_q = value;
   endtask

   always @(posedge clock) begin
      if (!reset) rsp_stall <= ($urandom_range(99) < idle_pct);
   end

   always @(posedge clock) begin
      adagrad_pkg::rsp_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_checked++;
         if (pending_steps.size() == 0) begin
            errors++;
            $display("%0t: unexpected result %h", $time, rsp_data);
         end else begin
            exp_r = pending_steps.pop_front();
            if (exp_r.saturated) n_sat++;
            if (rsp_data.result_index !== exp_r.result_index) begin
               errors++;
               $display("%0t: result_index expected %h actual %h", $time,
                        exp_r.result_index, rsp_data.result_index);
            end
            if (rsp_data.step !== exp_r.step) begin
               errors++;
               $display("%0t: step expected %h actual %h", $time,
                        exp_r.step, rsp_data.step);
            end
            if (rsp_data.saturated !== exp_r.saturated) begin
               errors++;
               $display("%0t: saturated expected %b actual %b", $time,
                        exp_r.saturated, rsp_data.saturated);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   task automatic test_directed();
      send_item(adagrad_pkg::MODE_UPDATE, 12'd0, 32'h0001_0000);
      send_item(adagrad_pkg::MODE_UPDATE, 12'd0, 32'hFFFF_0000);
      send_item(adagrad_pkg::MODE_UPDATE, 12'd4095, 32'h7FFF_FFFF);
      send_item(adagrad_pkg::MODE_UPDATE, 12'd4094, 32'h8000_0000);
      send_item(adagrad_pkg::MODE_UPDATE, 12'd5, 32'h0000_0000);
      send_item(adagrad_pkg::MODE_UPDATE, 12'd6, 32'h0000_0001);
      send_item(adagrad_pkg::MODE_UPDATE, 12'd7, 32'hFFFF_FFFF);
      repeat (6) send_item(adagrad_pkg::MODE_UPDATE, 12'd9, 32'h8000_0000);
      send_item(adagrad_pkg::MODE_UPDATE, 12'd9, 32'h0000_0000);
      send_item(adagrad_pkg::MODE_CLEAR, 12'd9, 32'h1234_5678);
      send_item(adagrad_pkg::MODE_UPDATE, 12'd9, 32'h0000_0100);
      send_item(adagrad_pkg::MODE_UPDATE, 12'd4095, 32'hFFFF_FFFF);
   endtask

   task automatic test_registers();
      write_reg(adagrad_pkg::CSR_EPSILON_BIAS, 32'd0);
      write_reg(adagrad_pkg::CSR_STEP_SIZE, 32'hFFFF_FFFF);
      send_item(adagrad_pkg::MODE_UPDATE, 12'd100, 32'd0);
      send_item(adagrad_pkg::MODE_UPDATE, 12'd101, 32'h0000_0001);
      send_item(adagrad_pkg::MODE_UPDATE, 12'd102, 32'hFFFF_FFFF);
      send_item(adagrad_pkg::MODE_UPDATE, 12'd103, 32'h7FFF_FFFF);
      write_reg(adagrad_pkg::CSR_EPSILON_BIAS, 32'hFFFF_FFFF);
      write_reg(adagrad_pkg::CSR_STEP_SIZE, 32'd0);
      send_item(adagrad_pkg::MODE_UPDATE, 12'd104, 32'h8000_0000);
      write_reg(adagrad_pkg::CSR_STEP_SIZE, 32'hFFFF_FFFF);
      send_item(adagrad_pkg::MODE_UPDATE, 12'd105, 32'h8000_0000);
   endtask

   task automatic random_phase(input int count, input int hot);
      logic [31:0] g;
      logic [11:0] idx;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(3))
            0: g = $urandom;
            1: g = $signed($urandom_range(2047)) - 1024;
            2: g = {{12{1'($urandom_range(1))}}, 20'($urandom)};
            default: g = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         endcase
         idx = ($urandom_range(3) != 0) ? 12'($urandom_range(hot)) : 12'($urandom);
         send_item(($urandom_range(299) == 0) ? adagrad_pkg::MODE_CLEAR
                                               : adagrad_pkg::MODE_UPDATE, idx, g);
      end
   endtask

   task automatic test_random();
      logic [31:0] settings [4][2];
      settings = '{'{32'h0001_0000, 32'd1}, '{32'h0000_0100, 32'h0000_8000},
                   '{32'hFFFF_FFFF, 32'd1}, '{32'($urandom), 32'($urandom)}};
      for (int s = 0; s < 4; s++) begin
         write_reg(adagrad_pkg::CSR_STEP_SIZE, settings[s][0]);
         write_reg(adagrad_pkg::CSR_EPSILON_BIAS, settings[s][1]);
         idle_pct = (s == 1) ? 0 : 31;
         random_phase(450, (s == 2) ? 3 : 63);
      end
      idle_pct = 31;
   endtask

   initial begin
      alpha_q = adagrad_pkg::STEP_SIZE_RESET;
      eps_q = adagrad_pkg::EPSILON_RESET;
      foreach (grad_sq_sum[i]) grad_sq_sum[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_registers();
      test_random();
      req_valid <= 1'b0;
      while (pending_steps.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d items (%0d clears), checked %0d results.",
               n_sent, n_clears, n_checked);
      $display("Saturated results seen: %0d.", n_sat);
      if (errors == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
